@@ hw/rtl/apw_pkg.sv @@
// Shared types and sizing constants for the average pooling window engine.
// No dependencies; every other file in hw/rtl but apw_ram refers to it by scoped names.
package apw_pkg;

	localparam int MAX_ELEMS  = 65536;
	localparam int MAX_KERNEL = 16;
	localparam int ADDR_W     = $clog2(MAX_ELEMS);
	localparam int CNT_W      = ADDR_W + 1;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMG_H    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_W    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_H = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_W = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDES  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PADS     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PARTY    = 4'd7;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_POOL = 1'b1;

	typedef struct packed {
		logic        op;
		logic [63:0] value;
		logic        last;
	} in_t;

	typedef struct packed {
		logic [63:0] average;
		logic        last_result;
	} out_t;

	typedef struct packed {
		logic [8:0]  img_h;
		logic [8:0]  img_w;
		logic [8:0]  channels;
		logic [4:0]  kernel_h;
		logic [4:0]  kernel_w;
		logic [7:0]  stride_sizes;
		logic [15:0] pad_sizes;
		logic        share_party;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic kill;
		logic start;
		logic div_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic frame_ready;
		logic empty;
		logic taps_done;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/avg_pool_window_engine.sv @@
// Top level of the zero padded average pooling engine: configuration registers,
// sequencer and datapath. Depends on apw_pkg, apw_ctrl, apw_dp (and apw_ram).
//
// A load word (op 0) writes the next frame store entry; the word with last
// set arms the output side. A pool word (op 1) sweeps the window one tap per
// cycle through a three stage address and store read pipeline, then runs a
// bit-serial divide by the kernel area, then loads the result register.
// One word is in work at a time; the next word is taken while a result still
// waits on a stalled output. Configuration writes are always ready and must
// only be made while the engine is idle.
module avg_pool_window_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  apw_pkg::in_t                       req_word,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output apw_pkg::out_t                      rsp_word,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [apw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	apw_pkg::cfg_t cfg_q;
	apw_pkg::cmd_t cmd;
	apw_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.img_h        <= 9'd1;
			cfg_q.img_w        <= 9'd1;
			cfg_q.channels     <= 9'd1;
			cfg_q.kernel_h     <= 5'd1;
			cfg_q.kernel_w     <= 5'd1;
			cfg_q.stride_sizes <= 8'd17;
			cfg_q.pad_sizes    <= 16'd0;
			cfg_q.share_party  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				apw_pkg::REG_IMG_H:    cfg_q.img_h        <= cfg_data[8:0];
				apw_pkg::REG_IMG_W:    cfg_q.img_w        <= cfg_data[8:0];
				apw_pkg::REG_CHANNELS: cfg_q.channels     <= cfg_data[8:0];
				apw_pkg::REG_KERNEL_H: cfg_q.kernel_h     <= cfg_data[4:0];
				apw_pkg::REG_KERNEL_W: cfg_q.kernel_w     <= cfg_data[4:0];
				apw_pkg::REG_STRIDES:  cfg_q.stride_sizes <= cfg_data[7:0];
				apw_pkg::REG_PADS:     cfg_q.pad_sizes    <= cfg_data;
				apw_pkg::REG_PARTY:    cfg_q.share_party  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	apw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req_word.op),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	apw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_word  (req_word),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule

@@ hw/rtl/apw_ram.sv @@
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module apw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hw/rtl/apw_ctrl.sv @@
// Sequencer for the pooling engine: accepts words, steps tap sweep, divide, emit.
// Depends on apw_pkg for command and status structs.
module apw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_op,
	output logic          req_stall,
	input  apw_pkg::sts_t sts,
	output apw_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TAPS = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_op == apw_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
					end else if (sts.frame_ready) begin
						if (sts.empty) begin
							cmd.kill = 1'b1;
						end else begin
							cmd.start = 1'b1;
							state_d   = ST_TAPS;
						end
					end
				end
			end
			ST_TAPS: begin
				if (sts.taps_done) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/apw_dp.sv @@
// Pooling datapath: frame store, tap address pipeline, accumulator, serial divider,
// output position and result register. Depends on apw_pkg and apw_ram.
module apw_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  apw_pkg::cfg_t  cfg,
	input  apw_pkg::in_t   req_word,
	input  apw_pkg::cmd_t  cmd,
	output apw_pkg::sts_t  sts,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output apw_pkg::out_t  rsp_word
);

	localparam int AW = apw_pkg::ADDR_W;
	localparam int CW = apw_pkg::CNT_W;

	// clamped configuration
	logic [8:0] ih, iw, ch;
	logic [4:0] kh, kw;
	logic [3:0] sh, sw, pt, pb, pl, pr;
	logic [9:0] span_h, span_w;

	always_comb begin
		ih = (cfg.img_h == 9'd0) ? 9'd1 : ((cfg.img_h > 9'd256) ? 9'd256 : cfg.img_h);
		iw = (cfg.img_w == 9'd0) ? 9'd1 : ((cfg.img_w > 9'd256) ? 9'd256 : cfg.img_w);
		ch = (cfg.channels == 9'd0) ? 9'd1 :
			((cfg.channels > 9'd256) ? 9'd256 : cfg.channels);
		kh = (cfg.kernel_h == 5'd0) ? 5'd1 :
			((cfg.kernel_h > 5'(apw_pkg::MAX_KERNEL)) ? 5'(apw_pkg::MAX_KERNEL) : cfg.kernel_h);
		kw = (cfg.kernel_w == 5'd0) ? 5'd1 :
			((cfg.kernel_w > 5'(apw_pkg::MAX_KERNEL)) ? 5'(apw_pkg::MAX_KERNEL) : cfg.kernel_w);
		sh = (cfg.stride_sizes[3:0] == 4'd0) ? 4'd1 : cfg.stride_sizes[3:0];
		sw = (cfg.stride_sizes[7:4] == 4'd0) ? 4'd1 : cfg.stride_sizes[7:4];
		pt = cfg.pad_sizes[3:0];
		pb = cfg.pad_sizes[7:4];
		pl = cfg.pad_sizes[11:8];
		pr = cfg.pad_sizes[15:12];
		span_h = {1'b0, ih} + {6'd0, pt} + {6'd0, pb};
		span_w = {1'b0, iw} + {6'd0, pl} + {6'd0, pr};
	end

	// frame and output position state
	logic [CW-1:0] load_cnt_q;
	logic          frame_ready_q;
	logic [8:0]    row_top_q, col_left_q;
	logic [7:0]    chan_q;

	// tap sweep
	logic       tap_active_q;
	logic [4:0] fh_q, fw_q;
	logic       v_s1, ok_s1, v_s2, ok_s2, v_s3, ok_s3;
	logic [16:0] pix_s1;
	logic [25:0] idx_s2;
	logic [63:0] sum_q;
	logic [63:0] ram_rdata;

	logic signed [10:0] r_pos, c_pos;
	logic r_in, c_in;
	logic [25:0] idx;

	assign r_pos = $signed({2'b00, row_top_q}) - $signed({7'd0, pt}) + $signed({6'd0, fh_q});
	assign c_pos = $signed({2'b00, col_left_q}) - $signed({7'd0, pl}) + $signed({6'd0, fw_q});
	assign r_in  = !r_pos[10] && (r_pos[9:0] < {1'b0, ih});
	assign c_in  = !c_pos[10] && (c_pos[9:0] < {1'b0, iw});
	assign idx   = ({9'd0, pix_s1} * {17'd0, ch}) + {18'd0, chan_q};

	logic ram_we;
	assign ram_we = cmd.load && (load_cnt_q < CW'(apw_pkg::MAX_ELEMS));

	apw_ram #(
		.WIDTH(64),
		.DEPTH(apw_pkg::MAX_ELEMS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (load_cnt_q[AW-1:0]),
		.wr_data (req_word.value),
		.rd_en   (v_s2),
		.rd_addr (idx_s2[AW-1:0]),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_active_q <= 1'b0;
			fh_q         <= '0;
			fw_q         <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
		end else begin
			v_s1 <= tap_active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.start) begin
				tap_active_q <= 1'b1;
				fh_q         <= '0;
				fw_q         <= '0;
			end else if (tap_active_q) begin
				if (fw_q == kw - 5'd1) begin
					fw_q <= '0;
					if (fh_q == kh - 5'd1) begin
						tap_active_q <= 1'b0;
					end else begin
						fh_q <= fh_q + 5'd1;
					end
				end else begin
					fw_q <= fw_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s1  <= r_in && c_in;
		pix_s1 <= ({9'd0, r_pos[7:0]} * {8'd0, iw}) + {9'd0, c_pos[7:0]};
		ok_s2  <= ok_s1 && (idx < 26'(apw_pkg::MAX_ELEMS));
		idx_s2 <= idx;
		ok_s3  <= v_s2 && ok_s2;
		if (cmd.start) begin
			sum_q <= '0;
		end else if (v_s3 && ok_s3) begin
			sum_q <= sum_q + ram_rdata;
		end
	end

	// restoring divider, one quotient bit per cycle; dvd_q ends as the quotient
	logic        div_active_q;
	logic [5:0]  div_cnt_q;
	logic [63:0] dvd_q;
	logic [8:0]  rem_q;
	logic        neg_q;
	logic [8:0]  area;
	logic [63:0] x_val;
	logic [9:0]  trial;
	logic        qbit;

	assign area  = {4'd0, kh} * {4'd0, kw};
	assign x_val = cfg.share_party ? (64'd0 - sum_q) : sum_q;
	assign trial = {rem_q, dvd_q[63]};
	assign qbit  = (trial >= {1'b0, area});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_active_q <= 1'b0;
			div_cnt_q    <= '0;
		end else if (cmd.div_start) begin
			div_active_q <= 1'b1;
			div_cnt_q    <= 6'd63;
		end else if (div_active_q) begin
			div_cnt_q <= div_cnt_q - 6'd1;
			if (div_cnt_q == 6'd0) begin
				div_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= x_val[63];
			dvd_q <= x_val[63] ? (64'd0 - x_val) : x_val;
			rem_q <= '0;
		end else if (div_active_q) begin
			rem_q <= qbit ? 9'(trial - {1'b0, area}) : trial[8:0];
			dvd_q <= {dvd_q[62:0], qbit};
		end
	end

	// next output position
	logic [9:0]  next_top, next_left;
	logic        row_fits, col_fits, chan_wrap;
	logic        fin;

	assign next_top  = {1'b0, row_top_q} + {6'd0, sh};
	assign next_left = {1'b0, col_left_q} + {6'd0, sw};
	assign row_fits  = ({1'b0, next_top} + {6'd0, kh}) <= {1'b0, span_h};
	assign col_fits  = ({1'b0, next_left} + {6'd0, kw}) <= {1'b0, span_w};
	assign chan_wrap = ({1'b0, chan_q} + 9'd1) >= ch;
	assign fin       = chan_wrap && !col_fits && !row_fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q    <= '0;
			frame_ready_q <= 1'b0;
			row_top_q     <= '0;
			col_left_q    <= '0;
			chan_q        <= '0;
		end else begin
			if (cmd.load) begin
				if (req_word.last) begin
					load_cnt_q    <= '0;
					frame_ready_q <= 1'b1;
					row_top_q     <= '0;
					col_left_q    <= '0;
					chan_q        <= '0;
				end else begin
					frame_ready_q <= 1'b0;
					if (ram_we) begin
						load_cnt_q <= load_cnt_q + CW'(1);
					end
				end
			end
			if (cmd.kill) begin
				frame_ready_q <= 1'b0;
			end
			if (cmd.emit) begin
				if (!chan_wrap) begin
					chan_q <= chan_q + 8'd1;
				end else begin
					chan_q <= '0;
					if (col_fits) begin
						col_left_q <= next_left[8:0];
					end else begin
						col_left_q <= '0;
						if (row_fits) begin
							row_top_q <= next_top[8:0];
						end else begin
							row_top_q     <= '0;
							frame_ready_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	// result register
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_word.average     <= (neg_q ^ cfg.share_party) ? (64'd0 - dvd_q) : dvd_q;
			rsp_word.last_result <= fin;
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		sts.frame_ready = frame_ready_q;
		sts.empty       = (span_h < {5'd0, kh}) || (span_w < {5'd0, kw});
		sts.taps_done   = !tap_active_q && !v_s1 && !v_s2 && !v_s3;
		sts.div_done    = !div_active_q;
		sts.out_free    = !rsp_valid_q || !rsp_stall;
	end

endmodule
